@@ rtl/core/ungs_pkg.sv @@
// Shared types and constants of the uniform grid neighbour search block.
package ungs_pkg;

   localparam int MAX_POINTS = 64;
   localparam int MAX_GRID_W = 32;
   localparam int MAX_GRID_H = 32;
   localparam int PT_AW      = 6;
   localparam int GX_W       = 5;
   localparam int GY_W       = 5;
   localparam int CELL_AW    = GX_W + GY_W;
   localparam int CELL_COUNT = MAX_GRID_W * MAX_GRID_H;
   localparam int POS_W      = 16;
   localparam int PROD_W     = 2 * POS_W;
   localparam int CRD_W      = 12;
   localparam int FRAC_SHIFT = 20;
   localparam int CSR_AW     = 2;
   localparam int DIM_W      = 6;

   localparam logic [POS_W-1:0] INV_CELL_RESET = 16'd1092;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_INV_CELL_SIZE = 2'd0,
      CSR_GRID_WIDTH    = 2'd1,
      CSR_GRID_HEIGHT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             occupied;
      logic [PT_AW-1:0] first;
      logic [PT_AW-1:0] last;
   } cell_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MULX,
      ST_MULY,
      ST_MULR,
      ST_WIN,
      ST_INS_C,
      ST_INS_UPD,
      ST_INS_LINK,
      ST_CELL_RD,
      ST_CELL_CHK,
      ST_PT_RD,
      ST_PT_DX,
      ST_PT_DY,
      ST_PT_CMP,
      ST_NEXT,
      ST_Q_END
   } state_type;

endpackage

@@ rtl/core/ungs_ram.sv @@
// Generic single write port RAM with registered read.
module ungs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/ungs_mul.sv @@
// Shared 16 by 16 unsigned multiplier with registered product.
module ungs_mul (
   input  logic                        clock,
   input  logic [ungs_pkg::POS_W-1:0]  a,
   input  logic [ungs_pkg::POS_W-1:0]  b,
   output logic [ungs_pkg::PROD_W-1:0] product
);

   logic [ungs_pkg::PROD_W-1:0] prod_ff;
   logic [ungs_pkg::PROD_W-1:0] prod_in;

   assign prod_in = ungs_pkg::PROD_W'(a) * ungs_pkg::PROD_W'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

@@ rtl/core/uniform_grid_neighbor_search.sv @@
// Uniform grid neighbour search: up to 32x32 cells and up to 64 points with
// per-cell linked lists. After reset, and for every clear item, the block
// sweeps the 1024-entry cell table one entry a cycle with req_ready low.
// Insert takes two multiplies, a cell table read and write, and a link
// write if the cell held points. A query scans up to 3x3 window cells and
// walks each cell's point list, then sends a final item; every multiply
// goes through one shared multiplier and each list step waits on a
// registered RAM read. Results leave through an output register and wait
// there while rsp_ready is low.
module uniform_grid_neighbor_search (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic [ungs_pkg::POS_W-1:0]           req_pos_x,
   input  logic [ungs_pkg::POS_W-1:0]           req_pos_y,
   input  logic [ungs_pkg::POS_W-1:0]           req_radius,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ungs_pkg::PT_AW-1:0]           rsp_neighbor_index,
   output logic                                 rsp_found,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [ungs_pkg::CSR_AW-1:0]          csr_index,
   input  logic [ungs_pkg::POS_W-1:0]           csr_wdata
);

   localparam int PW = ungs_pkg::POS_W;
   localparam int AW = ungs_pkg::PT_AW;
   localparam int CW = ungs_pkg::CRD_W;

   ungs_pkg::state_type state_ff, state_in;

   logic [PW-1:0] inv_ff, inv_in;
   logic [ungs_pkg::DIM_W-1:0] gw_ff, gw_in, gh_ff, gh_in;

   logic [1:0]    op_ff, op_in;
   logic [PW-1:0] x_ff, x_in, y_ff, y_in, r_ff, r_in;
   logic [AW:0]   count_ff, count_in;
   logic [AW-1:0] p_ff, p_in, last_ff, last_in, pend_ff, pend_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [ungs_pkg::CELL_AW-1:0] clr_ff, clr_in, c_ff, c_in;
   logic [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [ungs_pkg::PROD_W-1:0] rsq_ff, rsq_in, sum_ff, sum_in;
   logic [ungs_pkg::GX_W-1:0] gx_ff, gx_in, minx_ff, minx_in, maxx_ff, maxx_in;
   logic [ungs_pkg::GY_W-1:0] gy_ff, gy_in, maxy_ff, maxy_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_idx_ff, rsp_idx_in;
   logic          rsp_found_ff, rsp_found_in, rsp_last_ff, rsp_last_in;

   logic [PW-1:0] mul_a, mul_b;
   logic [ungs_pkg::PROD_W-1:0] prod;

   logic          xy_we, link_we, cell_we;
   logic [AW-1:0] xy_waddr, link_waddr, pt_raddr, link_wdata;
   logic [PW-1:0] px_rd, py_rd;
   logic [AW-1:0] link_rd;
   logic [ungs_pkg::CELL_AW-1:0] cell_waddr, cell_raddr;
   ungs_pkg::cell_entry_type cell_wdata, cell_rd;

   logic [ungs_pkg::GX_W-1:0] gwm1;
   logic [ungs_pkg::GY_W-1:0] ghm1;
   logic [CW-1:0] prod_crd, ins_cy, minx_w, maxx_w, miny_w, maxy_w;
   logic [CW:0]   cx_p1, cy_p1;
   logic          win_empty;
   logic [PW-1:0] diff_x, diff_y;
   logic [ungs_pkg::PROD_W:0] dist_sq;
   logic          out_free, hit;

   ungs_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .product(prod));

   ungs_ram #(.WIDTH(PW), .DEPTH(ungs_pkg::MAX_POINTS)) u_pt_x (
      .clock(clock), .we(xy_we), .waddr(xy_waddr), .wdata(x_ff),
      .raddr(pt_raddr), .rdata(px_rd));

   ungs_ram #(.WIDTH(PW), .DEPTH(ungs_pkg::MAX_POINTS)) u_pt_y (
      .clock(clock), .we(xy_we), .waddr(xy_waddr), .wdata(y_ff),
      .raddr(pt_raddr), .rdata(py_rd));

   ungs_ram #(.WIDTH(AW), .DEPTH(ungs_pkg::MAX_POINTS)) u_pt_link (
      .clock(clock), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .raddr(pt_raddr), .rdata(link_rd));

   ungs_ram #(.WIDTH($bits(ungs_pkg::cell_entry_type)), .DEPTH(ungs_pkg::CELL_COUNT))
   u_cell (
      .clock(clock), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
      .raddr(cell_raddr), .rdata(cell_rd));

   // saturate grid size into 1..MAX and keep the highest usable coordinate
   always_comb begin
      if (gw_ff == '0) begin
         gwm1 = '0;
      end else if (gw_ff > ungs_pkg::DIM_W'(ungs_pkg::MAX_GRID_W)) begin
         gwm1 = ungs_pkg::GX_W'(ungs_pkg::MAX_GRID_W - 1);
      end else begin
         gwm1 = ungs_pkg::GX_W'(gw_ff - 1'b1);
      end
      if (gh_ff == '0) begin
         ghm1 = '0;
      end else if (gh_ff > ungs_pkg::DIM_W'(ungs_pkg::MAX_GRID_H)) begin
         ghm1 = ungs_pkg::GY_W'(ungs_pkg::MAX_GRID_H - 1);
      end else begin
         ghm1 = ungs_pkg::GY_W'(gh_ff - 1'b1);
      end
   end

   assign prod_crd = prod[ungs_pkg::FRAC_SHIFT +: CW];
   assign ins_cy   = (prod_crd > CW'(ghm1)) ? CW'(ghm1) : prod_crd;

   assign cx_p1  = {1'b0, cx_ff} + 1'b1;
   assign cy_p1  = {1'b0, cy_ff} + 1'b1;
   assign minx_w = (cx_ff == '0) ? '0 : cx_ff - 1'b1;
   assign miny_w = (cy_ff == '0) ? '0 : cy_ff - 1'b1;
   assign maxx_w = (cx_p1 < (CW+1)'(gwm1)) ? cx_p1[CW-1:0] : CW'(gwm1);
   assign maxy_w = (cy_p1 < (CW+1)'(ghm1)) ? cy_p1[CW-1:0] : CW'(ghm1);
   assign win_empty = (minx_w > maxx_w) || (miny_w > maxy_w);

   assign diff_x  = (px_rd >= x_ff) ? px_rd - x_ff : x_ff - px_rd;
   assign diff_y  = (py_rd >= y_ff) ? py_rd - y_ff : y_ff - py_rd;
   assign dist_sq = {1'b0, sum_ff} + {1'b0, prod};
   assign hit     = dist_sq <= {1'b0, rsq_ff};

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ungs_pkg::ST_CLEAR;
         inv_ff        <= ungs_pkg::INV_CELL_RESET;
         gw_ff         <= ungs_pkg::DIM_W'(1);
         gh_ff         <= ungs_pkg::DIM_W'(1);
         count_ff      <= '0;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inv_ff        <= inv_in;
         gw_ff         <= gw_in;
         gh_ff         <= gh_in;
         count_ff      <= count_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      r_ff         <= r_in;
      p_ff         <= p_in;
      last_ff      <= last_in;
      pend_ff      <= pend_in;
      c_ff         <= c_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rsq_ff       <= rsq_in;
      sum_ff       <= sum_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      minx_ff      <= minx_in;
      maxx_ff      <= maxx_in;
      maxy_ff      <= maxy_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      inv_in        = inv_ff;
      gw_in         = gw_ff;
      gh_in         = gh_ff;
      op_in         = op_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      r_in          = r_ff;
      count_in      = count_ff;
      p_in          = p_ff;
      last_in       = last_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      clr_in        = clr_ff;
      c_in          = c_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      rsq_in        = rsq_ff;
      sum_in        = sum_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      minx_in       = minx_ff;
      maxx_in       = maxx_ff;
      maxy_in       = maxy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;

      req_ready  = 1'b0;
      mul_a      = x_ff;
      mul_b      = inv_ff;
      xy_we      = 1'b0;
      xy_waddr   = p_ff;
      link_we    = 1'b0;
      link_waddr = p_ff;
      link_wdata = '0;
      pt_raddr   = p_ff;
      cell_we    = 1'b0;
      cell_waddr = c_ff;
      cell_wdata = '0;
      cell_raddr = c_ff;

      if (csr_we) begin
         case (csr_index)
            ungs_pkg::CSR_INV_CELL_SIZE: inv_in = csr_wdata;
            ungs_pkg::CSR_GRID_WIDTH:    gw_in  = csr_wdata[ungs_pkg::DIM_W-1:0];
            ungs_pkg::CSR_GRID_HEIGHT:   gh_in  = csr_wdata[ungs_pkg::DIM_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ungs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_operation;
               x_in  = req_pos_x;
               y_in  = req_pos_y;
               r_in  = req_radius;
               p_in  = count_ff[AW-1:0];
               case (req_operation)
                  ungs_pkg::OP_CLEAR: begin
                     clr_in   = '0;
                     count_in = '0;
                     state_in = ungs_pkg::ST_CLEAR;
                  end
                  ungs_pkg::OP_INSERT: begin
                     // drop inserts once the point store is full
                     if (count_ff < (AW+1)'(ungs_pkg::MAX_POINTS)) begin
                        state_in = ungs_pkg::ST_MULX;
                     end
                  end
                  ungs_pkg::OP_QUERY: begin
                     pend_valid_in = 1'b0;
                     state_in      = ungs_pkg::ST_MULX;
                  end
                  default: ;
               endcase
            end
         end
         ungs_pkg::ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ungs_pkg::ST_IDLE;
            end
         end
         ungs_pkg::ST_MULX: begin
            mul_a    = x_ff;
            state_in = ungs_pkg::ST_MULY;
         end
         ungs_pkg::ST_MULY: begin
            cx_in = prod_crd;
            mul_a = y_ff;
            state_in = (op_ff == ungs_pkg::OP_INSERT) ? ungs_pkg::ST_INS_C
                                                      : ungs_pkg::ST_MULR;
         end
         ungs_pkg::ST_INS_C: begin
            c_in       = {ins_cy[ungs_pkg::GY_W-1:0],
                          ((cx_ff > CW'(gwm1)) ? gwm1 : cx_ff[ungs_pkg::GX_W-1:0])};
            cell_raddr = c_in;
            xy_we      = 1'b1;
            link_we    = 1'b1;
            state_in   = ungs_pkg::ST_INS_UPD;
         end
         ungs_pkg::ST_INS_UPD: begin
            cell_we             = 1'b1;
            cell_wdata.occupied = 1'b1;
            cell_wdata.first    = cell_rd.occupied ? cell_rd.first : p_ff;
            cell_wdata.last     = p_ff;
            last_in             = cell_rd.last;
            count_in            = count_ff + 1'b1;
            state_in = cell_rd.occupied ? ungs_pkg::ST_INS_LINK : ungs_pkg::ST_IDLE;
         end
         ungs_pkg::ST_INS_LINK: begin
            // chain the new point behind the previous tail of its cell
            link_we    = 1'b1;
            link_waddr = last_ff;
            link_wdata = p_ff;
            state_in   = ungs_pkg::ST_IDLE;
         end
         ungs_pkg::ST_MULR: begin
            cy_in    = prod_crd;
            mul_a    = r_ff;
            mul_b    = r_ff;
            state_in = ungs_pkg::ST_WIN;
         end
         ungs_pkg::ST_WIN: begin
            rsq_in  = prod;
            minx_in = minx_w[ungs_pkg::GX_W-1:0];
            maxx_in = maxx_w[ungs_pkg::GX_W-1:0];
            maxy_in = maxy_w[ungs_pkg::GY_W-1:0];
            gx_in   = minx_w[ungs_pkg::GX_W-1:0];
            gy_in   = miny_w[ungs_pkg::GY_W-1:0];
            state_in = win_empty ? ungs_pkg::ST_Q_END : ungs_pkg::ST_CELL_RD;
         end
         ungs_pkg::ST_CELL_RD: begin
            cell_raddr = {gy_ff, gx_ff};
            state_in   = ungs_pkg::ST_CELL_CHK;
         end
         ungs_pkg::ST_CELL_CHK: begin
            p_in    = cell_rd.first;
            last_in = cell_rd.last;
            state_in = cell_rd.occupied ? ungs_pkg::ST_PT_RD : ungs_pkg::ST_NEXT;
         end
         ungs_pkg::ST_PT_RD: begin
            pt_raddr = p_ff;
            state_in = ungs_pkg::ST_PT_DX;
         end
         ungs_pkg::ST_PT_DX: begin
            mul_a    = diff_x;
            mul_b    = diff_x;
            state_in = ungs_pkg::ST_PT_DY;
         end
         ungs_pkg::ST_PT_DY: begin
            sum_in   = prod;
            mul_a    = diff_y;
            mul_b    = diff_y;
            state_in = ungs_pkg::ST_PT_CMP;
         end
         ungs_pkg::ST_PT_CMP: begin
            // keep the square of dy in the multiplier while the output stalls
            mul_a = diff_y;
            mul_b = diff_y;
            // hold the newest hit back until we know whether it is the last
            if (!hit || !pend_valid_ff || out_free) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_idx_in   = pend_ff;
                     rsp_found_in = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = p_ff;
               end
               if (p_ff == last_ff) begin
                  state_in = ungs_pkg::ST_NEXT;
               end else begin
                  p_in     = link_rd;
                  state_in = ungs_pkg::ST_PT_RD;
               end
            end
         end
         ungs_pkg::ST_NEXT: begin
            if (gx_ff == maxx_ff) begin
               gx_in = minx_ff;
               if (gy_ff == maxy_ff) begin
                  state_in = ungs_pkg::ST_Q_END;
               end else begin
                  gy_in    = gy_ff + 1'b1;
                  state_in = ungs_pkg::ST_CELL_RD;
               end
            end else begin
               gx_in    = gx_ff + 1'b1;
               state_in = ungs_pkg::ST_CELL_RD;
            end
         end
         ungs_pkg::ST_Q_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = pend_valid_ff ? pend_ff : '0;
               rsp_found_in = pend_valid_ff;
               rsp_last_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in     = ungs_pkg::ST_IDLE;
            end
         end
         default: state_in = ungs_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_index = rsp_idx_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

@@ rtl/core/ungs_checker.sv @@
// Port-level checks of the neighbour search block, bound to the top level.
module ungs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [1:0]                  req_operation,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ungs_pkg::PT_AW-1:0]  rsp_neighbor_index,
   input logic                        rsp_found,
   input logic                        rsp_last
);

   // a stalled result transfer holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_neighbor_index)
                                  && $stable(rsp_found) && $stable(rsp_last))
      else $error("stalled result changed");

   // an empty answer is always the final item of its query
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last)
      else $error("empty result not marked last");

   // a query keeps the input side closed while it scans
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == ungs_pkg::OP_QUERY |=> !req_ready)
      else $error("ready during query");

   // the clearing pass after reset keeps the input closed
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready)
      else $error("ready straight after reset");

endmodule

bind uniform_grid_neighbor_search ungs_checker u_ungs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_operation(req_operation), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_neighbor_index(rsp_neighbor_index), .rsp_found(rsp_found),
   .rsp_last(rsp_last));
